// ===== rtl/core/bas_pkg.sv =====
// ----------------------------------------------------------------------------
// bas_pkg
// Shared types, constants and helpers of the ballistic aim solver.
// ----------------------------------------------------------------------------
`default_nettype none

package bas_pkg;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_GRAVITY      = 1'b0,
    CFG_LAUNCH_SPEED = 1'b1
  } cfg_idx_t;

  localparam int CFG_W = 31;
  localparam int POS_W = 32;

  localparam logic [CFG_W-1:0] GRAVITY_RST = 31'd642689;
  localparam logic [CFG_W-1:0] SPEED_RST   = 31'd327680;

  localparam int ANGLE_ITERATIONS_DEF = 24;
  // angle unit registers besides its rotation stages: input, 10 normalize, output
  localparam int ANG_FIXED_LAT = 12;

  localparam int ANG_W  = 23;
  localparam int ELEV_W = 24;
  localparam int AZ_W   = 25;

  localparam logic [ANG_W-1:0] ANG_RIGHT = 23'd5898240;   // 90 deg, Q.16
  localparam logic [AZ_W-1:0]  AZ_HALF   = 25'd11796480;  // 180 deg, Q.16

  // atan(2^-i) in degrees, Q.24
  function automatic logic [31:0] atan_tab(input int idx);
    logic [31:0] t;
    case (idx)
      0:  t = 32'd754974720;
      1:  t = 32'd445687602;
      2:  t = 32'd235489088;
      3:  t = 32'd119537938;
      4:  t = 32'd60000934;
      5:  t = 32'd30029717;
      6:  t = 32'd15018523;
      7:  t = 32'd7509720;
      8:  t = 32'd3754917;
      9:  t = 32'd1877466;
      10: t = 32'd938734;
      11: t = 32'd469367;
      12: t = 32'd234684;
      13: t = 32'd117342;
      14: t = 32'd58671;
      15: t = 32'd29335;
      16: t = 32'd14668;
      17: t = 32'd7334;
      18: t = 32'd3667;
      19: t = 32'd1833;
      20: t = 32'd917;
      21: t = 32'd458;
      22: t = 32'd229;
      23: t = 32'd115;
      24: t = 32'd57;
      25: t = 32'd29;
      26: t = 32'd14;
      27: t = 32'd7;
      28: t = 32'd4;
      29: t = 32'd2;
      30: t = 32'd1;
      default: t = 32'd0;
    endcase
    return t;
  endfunction

  // full 32x32 unsigned product
  function automatic logic [63:0] mul32(input logic [31:0] a, input logic [31:0] b);
    return {32'd0, a} * {32'd0, b};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ballistic_aim_solver_top.sv =====
// ----------------------------------------------------------------------------
// ballistic_aim_solver_top
// Aiming angles (azimuth, low-trajectory elevation) for a target position.
// ----------------------------------------------------------------------------
// A request is taken at a clock edge with start high; busy is always low, so
// a new target position may be given on every cycle. Positions are Q16.16
// metres; elevation comes back in Q8.16 and azimuth in Q9.16 degrees, with a
// reachable flag. Each result appears on the out_ ports for one cycle, marked
// by out_valid, in request order. Throughput is one request per cycle: every
// stage is its own register. The pipeline depth is set mainly by the 63-stage
// square root of the discriminant and the one-stage-per-iteration angle units.
// gravity and launch_speed are written through cfg_we/cfg_index/cfg_wdata,
// which the user must do only while no request is in flight (not enforced);
// a write takes effect for requests started on the next cycle.
// Reset (rst_n low at a clock edge) clears all in-flight requests and sets
// the registers to their defaults. The receiver cannot hold results off and
// the pipeline never stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module ballistic_aim_solver_top #(
  parameter int ANGLE_ITERATIONS = bas_pkg::ANGLE_ITERATIONS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [bas_pkg::POS_W-1:0] in_pos_x,
  input  logic signed [bas_pkg::POS_W-1:0] in_pos_y,
  input  logic signed [bas_pkg::POS_W-1:0] in_pos_z,
  input  logic                            cfg_we,
  input  bas_pkg::cfg_idx_t               cfg_index,
  input  logic [bas_pkg::CFG_W-1:0]       cfg_wdata,
  output logic                            out_valid,
  output logic signed [bas_pkg::ELEV_W-1:0] out_elevation_deg,
  output logic signed [bas_pkg::AZ_W-1:0]  out_azimuth_deg,
  output logic                            out_reachable
);

  import bas_pkg::*;

  localparam int ANG_LAT = ANGLE_ITERATIONS + ANG_FIXED_LAT;

  assign busy = 1'b0;

  // configuration registers and their derived products
  logic [CFG_W-1:0] grav_r, speed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grav_r  <= GRAVITY_RST;
      speed_r <= SPEED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRAVITY:      grav_r  <= cfg_wdata;
        CFG_LAUNCH_SPEED: speed_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [63:0]  v2_full, g2_full;
  logic [61:0]  v2_r, g2_r;
  logic [63:0]  gvl_r, gvh_r, vvll_r, vvlh_r, vvhh_r;
  logic [92:0]  gv2_r;
  logic [123:0] v4_r;

  assign v2_full = mul32({1'b0, speed_r}, {1'b0, speed_r});
  assign g2_full = mul32({1'b0, grav_r}, {1'b0, grav_r});

  always_ff @(posedge clk) begin
    v2_r   <= v2_full[61:0];
    g2_r   <= g2_full[61:0];
    gvl_r  <= mul32({1'b0, grav_r}, v2_r[31:0]);
    gvh_r  <= mul32({1'b0, grav_r}, {2'b00, v2_r[61:32]});
    vvll_r <= mul32(v2_r[31:0], v2_r[31:0]);
    vvlh_r <= mul32(v2_r[31:0], {2'b00, v2_r[61:32]});
    vvhh_r <= mul32({2'b00, v2_r[61:32]}, {2'b00, v2_r[61:32]});
    gv2_r  <= 93'(gvl_r) + (93'(gvh_r) << 32);
    v4_r   <= 124'(vvll_r) + (124'(vvlh_r) << 33) + (124'(vvhh_r) << 64);
  end

  // stage 1: magnitudes and signs
  logic        vld1_r, xneg1_r, yneg1_r, zneg1_r;
  logic [31:0] ux1_r, uy1_r, uz1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= start;
    end
    ux1_r   <= in_pos_x[31] ? (~in_pos_x + 32'd1) : in_pos_x;
    uy1_r   <= in_pos_y[31] ? (~in_pos_y + 32'd1) : in_pos_y;
    uz1_r   <= in_pos_z[31] ? (~in_pos_z + 32'd1) : in_pos_z;
    xneg1_r <= in_pos_x[31];
    yneg1_r <= in_pos_y[31];
    zneg1_r <= in_pos_z[31];
  end

  // stage 2: squares
  logic        vld2_r, yneg2_r;
  logic [31:0] uy2_r;
  logic [63:0] ux2_r, uz2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else begin
      vld2_r <= vld1_r;
    end
    ux2_r   <= mul32(ux1_r, ux1_r);
    uz2_r   <= mul32(uz1_r, uz1_r);
    uy2_r   <= uy1_r;
    yneg2_r <= yneg1_r;
  end

  // stage 3: ground distance squared
  logic        vld3_r, yneg3_r;
  logic [31:0] uy3_r;
  logic [63:0] s3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else begin
      vld3_r <= vld2_r;
    end
    s3_r    <= ux2_r + uz2_r;
    uy3_r   <= uy2_r;
    yneg3_r <= yneg2_r;
  end

  // stage 4: partial products of g^2 s and g v^2 |y|
  logic        vld4_r, yneg4_r;
  logic [63:0] pg00_r, pg01_r, pg10_r, pg11_r, py0_r, py1_r, py2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r <= 1'b0;
    end else begin
      vld4_r <= vld3_r;
    end
    pg00_r  <= mul32(g2_r[31:0], s3_r[31:0]);
    pg01_r  <= mul32(g2_r[31:0], s3_r[63:32]);
    pg10_r  <= mul32({2'b00, g2_r[61:32]}, s3_r[31:0]);
    pg11_r  <= mul32({2'b00, g2_r[61:32]}, s3_r[63:32]);
    py0_r   <= mul32(gv2_r[31:0], uy3_r);
    py1_r   <= mul32(gv2_r[63:32], uy3_r);
    py2_r   <= mul32({3'b000, gv2_r[92:64]}, uy3_r);
    yneg4_r <= yneg3_r;
  end

  // stage 5: sum partial products
  logic         vld5_r, yneg5_r;
  logic [127:0] neg5_r, ty5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld5_r <= 1'b0;
    end else begin
      vld5_r <= vld4_r;
    end
    neg5_r  <= 128'(pg00_r) + (128'(pg01_r) << 32) + (128'(pg10_r) << 32) +
               (128'(pg11_r) << 64);
    ty5_r   <= (128'(py0_r) + (128'(py1_r) << 32) + (128'(py2_r) << 64)) << 1;
    yneg5_r <= yneg4_r;
  end

  // stage 6: height term goes to the side that keeps both operands positive
  logic         vld6_r;
  logic [127:0] pos6_r, neg6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld6_r <= 1'b0;
    end else begin
      vld6_r <= vld5_r;
    end
    pos6_r <= 128'(v4_r) + (yneg5_r ? ty5_r : 128'd0);
    neg6_r <= neg5_r + (yneg5_r ? 128'd0 : ty5_r);
  end

  // stage 7: discriminant
  logic [128:0] disc;
  logic         vld7_r, reach7_r;
  logic [125:0] rad7_r;

  assign disc = {1'b0, pos6_r} - {1'b0, neg6_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld7_r <= 1'b0;
    end else begin
      vld7_r <= vld6_r;
    end
    reach7_r <= ~disc[128];
    rad7_r   <= disc[128] ? 126'd0 : disc[125:0];
  end

  // square roots
  logic        sqv_w, sqd_unused;
  logic [62:0] rt_w;
  logic [31:0] d_w, d70_w;
  logic        reach71_w;

  bas_sqrt #(.IN_W(126)) u_sqrt_disc (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vld7_r),
    .in_rad   (rad7_r),
    .out_vld  (sqv_w),
    .out_root (rt_w)
  );

  bas_sqrt #(.IN_W(64)) u_sqrt_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (vld3_r),
    .in_rad   (s3_r),
    .out_vld  (sqd_unused),
    .out_root (d_w)
  );

  bas_delay #(.W(32), .DEPTH(35)) u_dly_dist (
    .clk      (clk),
    .in_data  (d_w),
    .out_data (d70_w)
  );

  bas_delay #(.W(1), .DEPTH(64)) u_dly_reach (
    .clk      (clk),
    .in_data  (reach7_r),
    .out_data (reach71_w)
  );

  logic [65:0] az1_w, az71_w;
  assign az1_w = {ux1_r, uz1_r, xneg1_r, zneg1_r};

  bas_delay #(.W(66), .DEPTH(70)) u_dly_az (
    .clk      (clk),
    .in_data  (az1_w),
    .out_data (az71_w)
  );

  // stage 71: elevation operands
  logic [63:0] v2_ext, rt_ext;
  logic        vld71_r, nege71_r;
  logic [63:0] den71_r, num71_r;

  assign v2_ext = {2'b00, v2_r};
  assign rt_ext = {1'b0, rt_w};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld71_r <= 1'b0;
    end else begin
      vld71_r <= sqv_w;
    end
    den71_r  <= mul32({1'b0, grav_r}, d70_w);
    nege71_r <= (rt_ext > v2_ext);
    num71_r  <= (rt_ext > v2_ext) ? (rt_ext - v2_ext) : (v2_ext - rt_ext);
  end

  // angle units
  logic             ange_vld, anga_unused;
  logic [ANG_W-1:0] ang_e, ang_a;

  bas_angle #(.ITER(ANGLE_ITERATIONS)) u_ang_elev (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (vld71_r),
    .in_a    (den71_r),
    .in_b    (num71_r),
    .out_vld (ange_vld),
    .out_ang (ang_e)
  );

  bas_angle #(.ITER(ANGLE_ITERATIONS)) u_ang_az (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (vld71_r),
    .in_a    ({32'd0, az71_w[33:2]}),
    .in_b    ({32'd0, az71_w[65:34]}),
    .out_vld (anga_unused),
    .out_ang (ang_a)
  );

  // reach, elevation sign, x sign, z sign
  logic [3:0] side71_w, side_w;
  assign side71_w = {reach71_w, nege71_r, az71_w[1], az71_w[0]};

  bas_delay #(.W(4), .DEPTH(ANG_LAT)) u_dly_side (
    .clk      (clk),
    .in_data  (side71_w),
    .out_data (side_w)
  );

  // output register: sign and quadrant fixups
  logic [ELEV_W-1:0] e_mag, elev_nxt;
  logic [AZ_W-1:0]   a_mag, a_turn, az_nxt;
  logic              out_valid_r, reach_r;
  logic [ELEV_W-1:0] elev_r;
  logic [AZ_W-1:0]   az_r;

  assign e_mag    = {1'b0, ang_e};
  assign elev_nxt = !side_w[3] ? '0 : (side_w[2] ? (~e_mag + 1'b1) : e_mag);
  assign a_mag    = {2'b00, ang_a};
  assign a_turn   = side_w[0] ? (AZ_HALF - a_mag) : a_mag;
  assign az_nxt   = side_w[1] ? a_turn : (~a_turn + 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ange_vld;
    end
    elev_r  <= elev_nxt;
    az_r    <= az_nxt;
    reach_r <= side_w[3];
  end

  assign out_valid         = out_valid_r;
  assign out_elevation_deg = elev_r;
  assign out_azimuth_deg   = az_r;
  assign out_reachable     = reach_r;

endmodule

`default_nettype wire

// ===== rtl/core/bas_delay.sv =====
// ----------------------------------------------------------------------------
// bas_delay
// Fixed-length shift line that keeps side data aligned with the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module bas_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic [W-1:0] in_data,
  output logic [W-1:0] out_data
);

  logic [W-1:0] sh_r [0:DEPTH-1];

  always_ff @(posedge clk) begin
    sh_r[0] <= in_data;
    for (int k = 1; k < DEPTH; k++) begin
      sh_r[k] <= sh_r[k-1];
    end
  end

  assign out_data = sh_r[DEPTH-1];

endmodule

`default_nettype wire

// ===== rtl/core/bas_sqrt.sv =====
// ----------------------------------------------------------------------------
// bas_sqrt
// Pipelined integer floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bas_sqrt #(
  parameter int IN_W = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  logic [IN_W-1:0]   in_rad,
  output logic              out_vld,
  output logic [IN_W/2-1:0] out_root
);

  localparam int OW = IN_W / 2;

  logic            vld_r  [0:OW-1];
  logic [IN_W-1:0] rem_r  [0:OW-1];
  logic [OW-1:0]   root_r [0:OW-1];

  for (genvar k = 0; k < OW; k++) begin : g_bit
    localparam int B = OW - 1 - k;
    logic            v_i;
    logic [IN_W-1:0] rem_i;
    logic [OW-1:0]   root_i;
    logic [IN_W-1:0] trial;
    logic            take;

    if (k == 0) begin : g_head
      assign v_i    = in_vld;
      assign rem_i  = in_rad;
      assign root_i = '0;
    end else begin : g_tail
      assign v_i    = vld_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
    end

    // (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b)
    assign trial = ({{(IN_W-OW){1'b0}}, root_i} << (B + 1)) |
                   ({{(IN_W-1){1'b0}}, 1'b1} << (2 * B));
    assign take  = (rem_i >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= v_i;
      end
      rem_r[k]  <= take ? (rem_i - trial) : rem_i;
      root_r[k] <= take ? (root_i | ({{(OW-1){1'b0}}, 1'b1} << B)) : root_i;
    end
  end

  assign out_vld  = vld_r[OW-1];
  assign out_root = root_r[OW-1];

endmodule

`default_nettype wire

// ===== rtl/core/bas_angle.sv =====
// ----------------------------------------------------------------------------
// bas_angle
// First-quadrant angle of (a, b): staged normalize, then pipelined CORDIC.
// ----------------------------------------------------------------------------
`default_nettype none

module bas_angle #(
  parameter int ITER = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_vld,
  input  logic [63:0]              in_a,
  input  logic [63:0]              in_b,
  output logic                     out_vld,
  output logic [bas_pkg::ANG_W-1:0] out_ang
);

  import bas_pkg::*;

  localparam int NS = 10;

  logic        v0_r;
  logic [63:0] a0_r, b0_r, m0_r;
  logic        za0_r, zb0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= in_vld;
    end
    a0_r  <= in_a;
    b0_r  <= in_b;
    m0_r  <= (in_a > in_b) ? in_a : in_b;
    za0_r <= (in_a == 64'd0);
    zb0_r <= (in_b == 64'd0);
  end

  // normalize so the larger operand lies in [2^52, 2^53)
  logic        nv_r  [0:NS-1];
  logic [63:0] na_r  [0:NS-1];
  logic [63:0] nb_r  [0:NS-1];
  logic [63:0] nm_r  [0:NS-1];
  logic        nza_r [0:NS-1];
  logic        nzb_r [0:NS-1];

  for (genvar j = 0; j < NS; j++) begin : g_norm
    logic        v_i, za_i, zb_i, go;
    logic [63:0] a_i, b_i, m_i, a_n, b_n, m_n;

    if (j == 0) begin : g_head
      assign v_i  = v0_r;
      assign a_i  = a0_r;
      assign b_i  = b0_r;
      assign m_i  = m0_r;
      assign za_i = za0_r;
      assign zb_i = zb0_r;
    end else begin : g_tail
      assign v_i  = nv_r[j-1];
      assign a_i  = na_r[j-1];
      assign b_i  = nb_r[j-1];
      assign m_i  = nm_r[j-1];
      assign za_i = nza_r[j-1];
      assign zb_i = nzb_r[j-1];
    end

    if (j < 4) begin : g_right
      localparam int SH = 8 >> j;
      assign go  = |m_i[63:52+SH];
      assign a_n = go ? (a_i >> SH) : a_i;
      assign b_n = go ? (b_i >> SH) : b_i;
      assign m_n = go ? (m_i >> SH) : m_i;
    end else begin : g_left
      localparam int SH = 32 >> (j - 4);
      assign go  = ~|m_i[63:53-SH];
      assign a_n = go ? (a_i << SH) : a_i;
      assign b_n = go ? (b_i << SH) : b_i;
      assign m_n = go ? (m_i << SH) : m_i;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        nv_r[j] <= 1'b0;
      end else begin
        nv_r[j] <= v_i;
      end
      na_r[j]  <= a_n;
      nb_r[j]  <= b_n;
      nm_r[j]  <= m_n;
      nza_r[j] <= za_i;
      nzb_r[j] <= zb_i;
    end
  end

  // vectoring rotations
  logic               cv_r  [0:ITER-1];
  logic signed [55:0] cx_r  [0:ITER-1];
  logic signed [55:0] cy_r  [0:ITER-1];
  logic signed [32:0] cz_r  [0:ITER-1];
  logic               cza_r [0:ITER-1];
  logic               czb_r [0:ITER-1];

  for (genvar i = 0; i < ITER; i++) begin : g_rot
    localparam logic signed [32:0] TAB = {1'b0, atan_tab(i)};
    logic               v_i, za_i, zb_i;
    logic signed [55:0] x_i, y_i, dx, dy;
    logic signed [32:0] z_i;

    if (i == 0) begin : g_head
      assign v_i  = nv_r[NS-1];
      assign x_i  = {3'b000, na_r[NS-1][52:0]};
      assign y_i  = {3'b000, nb_r[NS-1][52:0]};
      assign z_i  = '0;
      assign za_i = nza_r[NS-1];
      assign zb_i = nzb_r[NS-1];
    end else begin : g_tail
      assign v_i  = cv_r[i-1];
      assign x_i  = cx_r[i-1];
      assign y_i  = cy_r[i-1];
      assign z_i  = cz_r[i-1];
      assign za_i = cza_r[i-1];
      assign zb_i = czb_r[i-1];
    end

    assign dx = y_i >>> i;
    assign dy = x_i >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[i] <= 1'b0;
      end else begin
        cv_r[i] <= v_i;
      end
      if (!y_i[55]) begin
        cx_r[i] <= x_i + dx;
        cy_r[i] <= y_i - dy;
        cz_r[i] <= z_i + TAB;
      end else begin
        cx_r[i] <= x_i - dx;
        cy_r[i] <= y_i + dy;
        cz_r[i] <= z_i - TAB;
      end
      cza_r[i] <= za_i;
      czb_r[i] <= zb_i;
    end
  end

  // round half up to Q.16 and clamp to [0, 90]
  logic signed [32:0] z_rnd, z_q;
  logic [ANG_W-1:0]   ang_nxt;
  logic               vld_r;
  logic [ANG_W-1:0]   ang_r;

  assign z_rnd = cz_r[ITER-1] + 33'sd128;
  assign z_q   = z_rnd >>> 8;

  always_comb begin
    if (czb_r[ITER-1]) begin
      ang_nxt = '0;
    end else if (cza_r[ITER-1]) begin
      ang_nxt = ANG_RIGHT;
    end else if (z_q[32]) begin
      ang_nxt = '0;
    end else if (z_q > $signed({10'd0, ANG_RIGHT})) begin
      ang_nxt = ANG_RIGHT;
    end else begin
      ang_nxt = z_q[ANG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= cv_r[ITER-1];
    end
    ang_r <= ang_nxt;
  end

  assign out_vld = vld_r;
  assign out_ang = ang_r;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ballistic aim solver. A directed table comes
// first: origin, vertical shots, targets behind, out-of-range targets and
// extreme positions. Random targets follow under several gravity and speed
// settings. Untyped results are compared with an in-bench angle-math model.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import bas_pkg::*;

  typedef struct {
    logic signed [ELEV_W-1:0] elev;
    logic signed [AZ_W-1:0]   az;
    logic                     reach;
  } aim_t;

  typedef struct {
    logic signed [31:0] x, y, z;
    bit                 typed;
    aim_t               want;
  } target_row_t;

  localparam int SOLVE_LAT = 24 + 84;
  localparam int WATCH_LIMIT = 4000;
  localparam int N_PHASE = 6;
  localparam longint ATAN_DEG [24] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684,
    117342, 58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [POS_W-1:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic cfg_we = 1'b0;
  cfg_idx_t cfg_index = CFG_GRAVITY;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic out_valid;
  logic signed [ELEV_W-1:0] out_elevation_deg;
  logic signed [AZ_W-1:0] out_azimuth_deg;
  logic out_reachable;

  ballistic_aim_solver_top u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_elevation_deg(out_elevation_deg),
    .out_azimuth_deg(out_azimuth_deg), .out_reachable(out_reachable)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [63:0] grav_q, speed_q;
  aim_t pending_aims[$];
  aim_t table_want;
  typedef logic [127:0] u128_t;
  bit forced_q[$];
  int errors = 0;
  int idle_cycles = 0;

  function automatic logic [63:0] isqrt(input logic [127:0] v);
    logic [127:0] r, t;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= v) r = t;
    end
    return r[63:0];
  endfunction

  // angle of (a, b) in the first quadrant, Q.16 degrees
  function automatic longint quad_angle(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] m;
    longint x, y, acc, dx, dy, r;
    if (b == 0) return 0;
    if (a == 0) return longint'(90) << 16;
    m = (a > b) ? a : b;
    while (m >= (64'd1 << 53)) begin
      a = a >> 1; b = b >> 1; m = m >> 1;
    end
    while (m < (64'd1 << 52)) begin
      a = a << 1; b = b << 1; m = m << 1;
    end
    x = longint'(a);
    y = longint'(b);
    acc = 0;
    for (int i = 0; i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; acc += ATAN_DEG[i];
      end else begin
        x -= dx; y += dy; acc -= ATAN_DEG[i];
      end
    end
    r = (acc + 128) >>> 8;
    if (r < 0) r = 0;
    if (r > (longint'(90) << 16)) r = longint'(90) << 16;
    return r;
  endfunction

  function automatic aim_t solve_aim(input logic signed [31:0] px, py, pz,
                                     input logic [63:0] g, v);
    aim_t res;
    longint x, y, z, el, az;
    logic [63:0] ux, uy, uz, s, v2, rt, den;
    u128_t pos, neg, ty;
    x = px; y = py; z = pz;
    ux = (x < 0) ? -x : x;
    uy = (y < 0) ? -y : y;
    uz = (z < 0) ? -z : z;
    s = ux * ux + uz * uz;
    v2 = v * v;
    pos = u128_t'(v2) * u128_t'(v2);
    ty = (u128_t'(g * uy) * u128_t'(v2)) << 1;
    neg = u128_t'(g * g) * u128_t'(s);
    if (y < 0) pos = pos + ty;
    else neg = neg + ty;
    res.reach = (pos >= neg);
    el = 0;
    if (res.reach) begin
      rt = isqrt(pos - neg);
      den = g * isqrt(u128_t'(s));
      if (v2 >= rt) el = quad_angle(den, v2 - rt);
      else el = -quad_angle(den, rt - v2);
    end
    az = quad_angle(uz, ux);
    if (z < 0) az = (longint'(180) << 16) - az;
    if (x < 0) az = -az;
    az = -az;
    res.elev = el[ELEV_W-1:0];
    res.az = az[AZ_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // request capture, config mirror and result check
  always @(posedge clk) begin
    aim_t want;
    if (!rst_n) begin
      grav_q <= 64'(GRAVITY_RST);
      speed_q <= 64'(SPEED_RST);
    end else begin
      if (out_valid) begin
        if (pending_aims.size() == 0) begin
          report_mismatch("unexpected result", out_elevation_deg, 0);
        end else begin
          want = pending_aims.pop_front();
          if (out_elevation_deg !== want.elev)
            report_mismatch("elevation", out_elevation_deg, want.elev);
          if (out_azimuth_deg !== want.az)
            report_mismatch("azimuth", out_azimuth_deg, want.az);
          if (out_reachable !== want.reach)
            report_mismatch("reachable", out_reachable, want.reach);
        end
      end
      if (start && !busy) begin
        want = solve_aim(in_pos_x, in_pos_y, in_pos_z, grav_q, speed_q);
        if (forced_q.size() != 0 && forced_q[0]) want = table_want;
        if (forced_q.size() != 0) void'(forced_q.pop_front());
        pending_aims.insert(pending_aims.size(), want);
      end
      if (cfg_we) begin
        if (cfg_index == CFG_GRAVITY) grav_q <= 64'(cfg_wdata);
        else speed_q <= 64'(cfg_wdata);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && ((start && !busy) || out_valid || cfg_we))
      idle_cycles <= 0;
    else if (rst_n)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("FAIL ballistic_aim_solver_top");
      $finish;
    end
  end

  task automatic send_target(input logic signed [31:0] x, y, z);
    start <= 1'b1;
    in_pos_x <= x; in_pos_y <= y; in_pos_z <= z;
    do @(posedge clk); while (busy);
  endtask

  task automatic hold_off(input int pct);
    while ($urandom_range(99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_aims.size() != 0) @(posedge clk);
    repeat (SOLVE_LAT + 10) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_coord();
    logic [31:0] r;
    r = $urandom >> $urandom_range(0, 31);
    return $urandom_range(1) ? -$signed(r) : $signed(r);
  endfunction

  target_row_t rows[$];
  logic [CFG_W-1:0] phase_g[N_PHASE] = '{GRAVITY_RST, 31'd1, 31'h7fffffff, 31'd0,
                                         31'h7fffffff, 31'd642689};
  logic [CFG_W-1:0] phase_v[N_PHASE] = '{SPEED_RST, 31'h7fffffff, 31'd1, 31'd0,
                                         31'h7fffffff, 31'd3276800};

  task automatic add_row(input target_row_t r);
    rows.insert(rows.size(), r);
  endtask

  initial begin
    int pct;
    int near_shift;
    logic signed [31:0] MX, MN;
    MX = 32'sh7fffffff;
    MN = 32'sh80000000;
    // typed rows: origin, vertical shots, out of range, straight sideways
    add_row('{0, 0, 0, 1, '{0, 0, 1}});
    add_row('{0, 65536, 0, 1, '{24'sd5898240, 0, 1}});
    add_row('{0, -65536, 0, 1, '{-24'sd5898240, 0, 1}});
    add_row('{0, 0, MX, 1, '{0, 0, 0}});
    add_row('{0, MX, 0, 1, '{0, 0, 0}});
    // predicted rows
    add_row('{MX, MX, MX, 0, '{0, 0, 0}});
    add_row('{0, 0, -65536, 0, '{0, 0, 0}});
    add_row('{0, 0, MN, 0, '{0, 0, 0}});
    add_row('{1, 0, 0, 0, '{0, 0, 0}});
    add_row('{-1, 0, 0, 0, '{0, 0, 0}});
    add_row('{65536, 0, 65536, 0, '{0, 0, 0}});
    add_row('{-65536, 32768, -65536, 0, '{0, 0, 0}});
    add_row('{MN, MN, MN, 0, '{0, 0, 0}});
    add_row('{MX, MN, MN, 0, '{0, 0, 0}});
    add_row('{0, MN, 0, 0, '{0, 0, 0}});
    add_row('{MN, 0, 0, 0, '{0, 0, 0}});
    add_row('{0, -32768, 131072, 0, '{0, 0, 0}});
    add_row('{100000, -200000, -50000, 0, '{0, 0, 0}});
    add_row('{-1, -1, -1, 0, '{0, 0, 0}});
    add_row('{1, 1, 1, 0, '{0, 0, 0}});

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) begin
      table_want = rows[i].typed ? rows[i].want : table_want;
      forced_q.insert(forced_q.size(), rows[i].typed);
      send_target(rows[i].x, rows[i].y, rows[i].z);
      // typed row must be captured before the next row alters the expectation
      start <= 1'b0;
      @(posedge clk);
    end
    // full pause until every directed request has come back
    drain();

    for (int p = 0; p < N_PHASE; p++) begin
      write_reg(CFG_GRAVITY, phase_g[p]);
      write_reg(CFG_LAUNCH_SPEED, phase_v[p]);
      pct = (p < 2) ? 31 : (p < 4) ? 63 : 0;
      // shift that keeps targets near the reachable range of this setting
      near_shift = (phase_v[p] > 31'h00ffffff) ? 4 : 14;
      for (int n = 0; n < 165; n++) begin
        hold_off(pct);
        forced_q.insert(forced_q.size(), 1'b0);
        if ($urandom_range(3) == 0)
          send_target(rand_coord(), rand_coord(), rand_coord());
        else
          send_target($signed($urandom) >>> near_shift, $signed($urandom) >>> near_shift,
                      $signed($urandom) >>> near_shift);
      end
      drain();
    end

    if (errors == 0)
      $display("PASS ballistic_aim_solver_top");
    else
      $display("FAIL ballistic_aim_solver_top");
    $finish;
  end

endmodule

`default_nettype wire
